FILE: hdl/sfr_pkg.sv
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

   // configuration register layout
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned LEN_W       = 4;
   localparam int unsigned BYTE_W      = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_VALUE_BYTES    = 2'd2,
      CSR_VALUE_LENGTH   = 2'd3
   } csr_index_type;

   // source of the result word
   typedef enum logic [1:0] {
      OUT_WIN,
      OUT_VAL,
      OUT_EMPTY
   } out_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        append;
      logic        shift_win;
      logic        clear_win;
      logic        val_start;
      logic        val_next;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic p_zero;
      logic full;
      logic match;
      logic win_empty;
      logic count_one;
      logic v_zero;
      logic val_at_end;
      logic last_seen;
   } status_type;

endpackage

FILE: hdl/sfr_if.sv
// stream channel interfaces for source words and result words

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output has_byte, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input has_byte, input out_last,
                 output ready);
endinterface

FILE: hdl/sfr_datapath.sv
// window, configuration registers, pattern compare and result mux
module sfr_datapath #(
   parameter int unsigned PATTERN_MAX = 8,
   parameter int unsigned VALUE_MAX   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                          in_byte,
   input  logic                                in_last,
   input  sfr_pkg::cmd_type                    cmd,
   output sfr_pkg::status_type                 status,
   output logic [7:0]                          out_byte,
   output logic                                has_byte,
   output logic                                out_last
);

   localparam int unsigned CNT_W  = $clog2(PATTERN_MAX + 1);
   localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int unsigned VCNT_W = $clog2(VALUE_MAX + 1);
   localparam int unsigned VIDX_W = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

   logic [sfr_pkg::CSR_DATA_W-1:0] pat_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]      pat_len_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] val_bytes_ff;
   logic [sfr_pkg::LEN_W-1:0]      val_len_ff;
   logic [7:0]                     win_ff [PATTERN_MAX];
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [VIDX_W-1:0]              val_idx_ff;
   logic                           last_ff;

   logic [CNT_W-1:0]  p_eff;
   logic [VCNT_W-1:0] v_eff;
   logic [CNT_W-1:0]  wr_pos;
   logic              match;

   // lengths clamped to the hardware maximum
   assign p_eff = (pat_len_ff > sfr_pkg::LEN_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX)
                                                            : pat_len_ff[CNT_W-1:0];
   assign v_eff = (val_len_ff > sfr_pkg::LEN_W'(VALUE_MAX)) ? VCNT_W'(VALUE_MAX)
                                                           : val_len_ff[VCNT_W-1:0];

   // slot taken by the incoming word
   always_comb begin
      if (p_eff == '0) begin
         wr_pos = '0;
      end else if (count_ff >= p_eff) begin
         wr_pos = p_eff - CNT_W'(1);
      end else begin
         wr_pos = count_ff;
      end
   end

   // window against pattern over the used length
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((CNT_W'(i) < p_eff) && (win_ff[i] != pat_bytes_ff[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   // next window fill count
   always_comb begin
      count_in = count_ff;
      if (csr_write_en && (csr_index == sfr_pkg::CSR_PATTERN_LENGTH)) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = wr_pos + CNT_W'(1);
      end else if (cmd.clear_win) begin
         count_in = '0;
      end else if (cmd.shift_win) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         val_bytes_ff <= '0;
         val_len_ff   <= '0;
         count_ff     <= '0;
         last_ff      <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_write_en) begin
            case (csr_index)
               sfr_pkg::CSR_PATTERN_BYTES:  pat_bytes_ff <= csr_wdata;
               sfr_pkg::CSR_PATTERN_LENGTH: pat_len_ff   <= csr_wdata[sfr_pkg::LEN_W-1:0];
               sfr_pkg::CSR_VALUE_BYTES:    val_bytes_ff <= csr_wdata;
               sfr_pkg::CSR_VALUE_LENGTH:   val_len_ff   <= csr_wdata[sfr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.append) begin
            last_ff <= in_last;
         end
      end
   end

   // window storage and value index
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         win_ff[wr_pos[IDX_W-1:0]] <= in_byte;
      end else if (cmd.shift_win) begin
         for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
      end
      if (cmd.val_start) begin
         val_idx_ff <= '0;
      end else if (cmd.val_next) begin
         val_idx_ff <= val_idx_ff + VIDX_W'(1);
      end
   end

   // status back to the controller
   always_comb begin
      status.p_zero     = (p_eff == '0);
      status.full       = (p_eff != '0) && (count_ff == p_eff);
      status.match      = match;
      status.win_empty  = (count_ff == '0);
      status.count_one  = (count_ff == CNT_W'(1));
      status.v_zero     = (v_eff == '0);
      status.val_at_end = (VCNT_W'(val_idx_ff) == (v_eff - VCNT_W'(1)));
      status.last_seen  = last_ff;
   end

   // result word
   always_comb begin
      out_last = cmd.out_last;
      case (cmd.out_sel)
         sfr_pkg::OUT_WIN: begin
            out_byte = win_ff[0];
            has_byte = 1'b1;
         end
         sfr_pkg::OUT_VAL: begin
            out_byte = val_bytes_ff[8*val_idx_ff +: 8];
            has_byte = 1'b1;
         end
         default: begin
            out_byte = '0;
            has_byte = 1'b0;
         end
      endcase
   end

endmodule

FILE: hdl/sfr_ctrl.sv
// controller state machine: accept, check, then emit result words
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sfr_pkg::status_type status,
   output sfr_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WIN,
      S_VAL,
      S_EMPTY
   } state_type;

   state_type state_ff, state_in;
   logic      one_ff, one_in;

   // state and emit-one flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         one_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         one_ff   <= one_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      one_in    = one_ff;
      cmd       = '0;
      cmd.out_sel = sfr_pkg::OUT_EMPTY;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.append = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.p_zero) begin
               // pass through: the one stored word goes out as a flush
               one_in   = 1'b0;
               state_in = S_WIN;
            end else if (status.full && status.match) begin
               cmd.clear_win = 1'b1;
               cmd.val_start = 1'b1;
               if (!status.v_zero) begin
                  state_in = S_VAL;
               end else if (status.last_seen) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.full) begin
               // mismatch: oldest word out, or whole window on the final word
               one_in   = !status.last_seen;
               state_in = S_WIN;
            end else if (status.last_seen) begin
               one_in   = 1'b0;
               state_in = status.win_empty ? S_EMPTY : S_WIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WIN: begin
            rsp_valid    = 1'b1;
            cmd.out_sel  = sfr_pkg::OUT_WIN;
            cmd.out_last = status.last_seen && !one_ff && status.count_one;
            if (rsp_ready) begin
               cmd.shift_win = 1'b1;
               if (one_ff || status.count_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_VAL: begin
            rsp_valid    = 1'b1;
            cmd.out_sel  = sfr_pkg::OUT_VAL;
            cmd.out_last = status.last_seen && status.val_at_end;
            if (rsp_ready) begin
               cmd.val_next = 1'b1;
               if (status.val_at_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMPTY: begin
            rsp_valid    = 1'b1;
            cmd.out_sel  = sfr_pkg::OUT_EMPTY;
            cmd.out_last = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/stream_find_and_replace_top.sv
// top level of the stream find-and-replace block
//
// The req_chan channel takes one source byte per word, with in_last on the
// final byte of a stream. The rsp_chan channel gives the rewritten stream one
// byte per word; has_byte low marks an empty end word, and out_last flags the
// final word of the output stream. Pattern and replacement are set through the
// csr_ write port while the block is idle; writing the pattern length drops
// any pending window bytes.
// Each source word passes through an accept state and a compare state in the
// controller, then its result words go out one per cycle while the receiver
// is ready; a word produces up to 8 results, and one that only fills the
// window produces none. The controller handles one source word at a time.
// A stalled receiver holds the current result word steady and the block
// takes no new source word until all results of the current one are taken.
// Synchronous reset returns to idle, clears the window count and sets all
// configuration registers to zero (pass-through mode).
module stream_find_and_replace_top #(
   parameter int unsigned PATTERN_MAX = 8,
   parameter int unsigned VALUE_MAX   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   sfr_req_if.sink                         req_chan,
   sfr_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;
   logic [7:0]          out_byte;
   logic                has_byte;
   logic                out_last;

   // controller
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sfr_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .VALUE_MAX   (VALUE_MAX)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_byte      (req_chan.in_byte),
      .in_last      (req_chan.in_last),
      .cmd          (cmd),
      .status       (status),
      .out_byte     (out_byte),
      .has_byte     (has_byte),
      .out_last     (out_last)
   );

   // channel hookup
   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.out_byte = out_byte;
   assign rsp_chan.has_byte = has_byte;
   assign rsp_chan.out_last = out_last;

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the stream find-and-replace block
`timescale 1ns / 100ps

module tb;

   localparam int PATTERN_MAX  = 8;
   localparam int VALUE_MAX    = 8;
   localparam int SETTLE       = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 190;

   // one result word as seen on the result channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
   } out_word_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   sfr_req_if req_chan_if ();
   sfr_rsp_if rsp_chan_if ();

   stream_find_and_replace_top #(
      .PATTERN_MAX (PATTERN_MAX),
      .VALUE_MAX   (VALUE_MAX)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan_if),
      .rsp_chan     (rsp_chan_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow copy of the configuration and the match window
   logic [63:0] cfg_pattern;
   logic [3:0]  cfg_pattern_len;
   logic [63:0] cfg_value;
   logic [3:0]  cfg_value_len;
   logic [7:0]  win_bytes [PATTERN_MAX];
   int          win_fill;

   // predicted output stream, oldest word first
   out_word_type out_stream_q [$];

   bit reset_done  = 1'b0;
   bit steady      = 1'b0;
   int words_sent  = 0;
   int words_seen  = 0;
   int setups_done = 0;
   int fail_count  = 0;

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic int pattern_used();
      return (cfg_pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_pattern_len);
   endfunction

   function automatic void add_word(logic [7:0] b, logic has);
      out_word_type w;
      w.out_byte = b;
      w.has_byte = has;
      w.out_last = 1'b0;
      out_stream_q.push_back(w);
   endfunction

   // rewrite one source byte into the result words it causes
   function automatic void rewrite_byte(logic [7:0] b, logic last);
      int           p;
      int           v;
      int           before_n;
      int           tail;
      bit           hit;
      out_word_type w;
      p = pattern_used();
      v = (cfg_value_len > VALUE_MAX) ? VALUE_MAX : int'(cfg_value_len);
      before_n = out_stream_q.size();
      if (p == 0) begin
         win_fill = 0;
         add_word(b, 1'b1);
      end else begin
         if (win_fill >= p) win_fill = p - 1;
         win_bytes[win_fill] = b;
         win_fill++;
         // full window: compare against the pattern
         if (win_fill == p) begin
            hit = 1'b1;
            for (int i = 0; i < p; i++)
               if (win_bytes[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (int i = 0; i < v; i++) add_word(cfg_value[8*i +: 8], 1'b1);
               win_fill = 0;
            end else begin
               add_word(win_bytes[0], 1'b1);
               for (int i = 1; i < p; i++) win_bytes[i-1] = win_bytes[i];
               win_fill = p - 1;
            end
         end
         // end of stream flushes what is pending
         if (last) begin
            for (int i = 0; i < win_fill; i++) add_word(win_bytes[i], 1'b1);
            win_fill = 0;
         end
      end
      if (last) begin
         if (out_stream_q.size() == before_n) add_word(8'h00, 1'b0);
         tail = out_stream_q.size() - 1;
         w = out_stream_q[tail];
         w.out_last = 1'b1;
         out_stream_q[tail] = w;
      end
   endfunction

   // send one source word and predict its results once accepted
   task automatic push_source_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan_if.valid   <= 1'b1;
      req_chan_if.in_byte <= b;
      req_chan_if.in_last <= last;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      rewrite_byte(b, last);
      words_sent++;
   endtask

   // stop sending and wait until the block has nothing left to give
   task automatic wait_for_idle();
      req_chan_if.valid <= 1'b0;
      while (out_stream_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input sfr_pkg::csr_index_type idx, input logic [63:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         sfr_pkg::CSR_PATTERN_BYTES: begin
            cfg_pattern = data;
         end
         sfr_pkg::CSR_PATTERN_LENGTH: begin
            cfg_pattern_len = data[3:0];
            win_fill = 0;
         end
         sfr_pkg::CSR_VALUE_BYTES: begin
            cfg_value = data;
         end
         default: begin
            cfg_value_len = data[3:0];
         end
      endcase
   endtask

   // reprogram all four registers while idle; upper length bits are junk
   task automatic configure(input logic [63:0] pattern, input logic [3:0] plen,
                            input logic [63:0] value, input logic [3:0] vlen);
      logic [63:0] junk;
      wait_for_idle();
      junk = {$urandom, $urandom};
      write_reg(sfr_pkg::CSR_PATTERN_BYTES, pattern);
      write_reg(sfr_pkg::CSR_PATTERN_LENGTH, {junk[63:4], plen});
      junk = {$urandom, $urandom};
      write_reg(sfr_pkg::CSR_VALUE_BYTES, value);
      write_reg(sfr_pkg::CSR_VALUE_LENGTH, {junk[63:4], vlen});
      csr_write_en <= 1'b0;
      setups_done++;
   endtask

   // build a stream mostly from pattern pieces, with some noise
   task automatic send_random_stream(input int max_len, input bit with_last);
      logic [7:0] bytes_q [$];
      int         p;
      int         k;
      int         n;
      int         target;
      int         pause_at;
      p = pattern_used();
      target = $urandom_range(1, max_len);
      while (bytes_q.size() < target) begin
         k = $urandom_range(0, 9);
         if (p > 0 && k < 4) begin
            for (int i = 0; i < p; i++) bytes_q.push_back(cfg_pattern[8*i +: 8]);
         end else if (p > 1 && k < 6) begin
            n = $urandom_range(1, p - 1);
            for (int i = 0; i < n; i++) bytes_q.push_back(cfg_pattern[8*i +: 8]);
         end else if (p > 0 && k < 8) begin
            n = $urandom_range(0, p - 1);
            bytes_q.push_back(cfg_pattern[8*n +: 8]);
         end else begin
            bytes_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, bytes_q.size() - 1) : -1;
      for (int i = 0; i < bytes_q.size(); i++) begin
         if (i == pause_at) wait_for_idle();
         push_source_byte(bytes_q[i], with_last && (i == bytes_q.size() - 1));
      end
   endtask

   // reset state is pass-through
   task automatic test_pass_through();
      push_source_byte(8'h00, 1'b0);
      push_source_byte(8'hFF, 1'b0);
      push_source_byte(8'h5A, 1'b1);
   endtask

   // two-byte pattern replaced by a longer string, match on the final byte
   task automatic test_replace();
      configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      push_source_byte(8'h63, 1'b0);
      push_source_byte(8'h61, 1'b0);
      push_source_byte(8'h62, 1'b0);
      push_source_byte(8'h61, 1'b0);
      push_source_byte(8'h61, 1'b0);
      push_source_byte(8'h62, 1'b1);
   endtask

   // deleting the whole stream gives the empty end word
   task automatic test_empty_end();
      configure(64'hC33CA5, 4'd3, 64'h0, 4'd0);
      push_source_byte(8'hA5, 1'b0);
      push_source_byte(8'h3C, 1'b0);
      push_source_byte(8'hC3, 1'b1);
      push_source_byte(8'hA5, 1'b1);
   endtask

   // lengths above the maximum are clamped
   task automatic test_oversized_lengths();
      configure({64{1'b1}}, 4'hF, {$urandom, $urandom}, 4'hC);
      repeat (8) push_source_byte(8'hFF, 1'b0);
      push_source_byte(8'h00, 1'b0);
      push_source_byte(8'hFF, 1'b1);
   endtask

   // rewriting the pattern length drops the pending window
   task automatic test_window_drop();
      configure(64'h7A797877, 4'd4, 64'h21, 4'd1);
      push_source_byte(8'h77, 1'b0);
      push_source_byte(8'h78, 1'b0);
      configure(64'h7A797877, 4'd4, 64'h21, 4'd1);
      push_source_byte(8'h7A, 1'b1);
   endtask

   // random settings and streams, extremes first
   task automatic test_random_streams();
      int          stop_at;
      int          phase;
      int          r;
      logic [3:0]  plen;
      logic [3:0]  vlen;
      int          streams;
      stop_at = words_sent + RANDOM_WORDS;
      phase = 0;
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 19);
         case (phase)
            0: begin
               plen = 4'd8;
               vlen = 4'd8;
            end
            1: begin
               plen = 4'd1;
               vlen = 4'd0;
            end
            2: begin
               plen = 4'd0;
               vlen = 4'(($urandom_range(0, 15)));
            end
            default: begin
               if (r < 14) plen = 4'($urandom_range(1, 4));
               else if (r < 17) plen = 4'($urandom_range(5, 8));
               else if (r < 19) plen = 4'd0;
               else plen = 4'($urandom_range(9, 15));
               vlen = 4'($urandom_range(0, 15));
            end
         endcase
         configure({$urandom, $urandom}, plen, {$urandom, $urandom}, vlen);
         steady = ($urandom_range(0, 4) == 0);
         streams = $urandom_range(1, 4);
         for (int s = 0; s < streams; s++)
            send_random_stream(16, !((s == streams - 1) && ($urandom_range(0, 5) == 0)));
         phase++;
      end
      steady = 1'b0;
   endtask

   // result side: random stalls, each word checked against the prediction
   initial begin : rsp_checker
      out_word_type got;
      out_word_type want;
      int           gap;
      rsp_chan_if.ready = 1'b0;
      wait (reset_done);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_chan_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan_if.valid) @(posedge clock);
         got.out_byte = rsp_chan_if.out_byte;
         got.has_byte = rsp_chan_if.has_byte;
         got.out_last = rsp_chan_if.out_last;
         words_seen++;
         if (out_stream_q.size() == 0) begin
            if (fail_count < 10)
               $display("tb: unexpected word byte=%h has=%b last=%b",
                        got.out_byte, got.has_byte, got.out_last);
            fail_count++;
         end else begin
            want = out_stream_q.pop_front();
            if (got != want) begin
               if (fail_count < 10)
                  $display("tb: mismatch exp byte=%h has=%b last=%b, got byte=%h has=%b last=%b",
                           want.out_byte, want.has_byte, want.out_last,
                           got.out_byte, got.has_byte, got.out_last);
               fail_count++;
            end
         end
      end
   end

   // hard stop if the run hangs
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: timeout after %0d cycles", CYCLE_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   initial begin : main
      req_chan_if.valid   = 1'b0;
      req_chan_if.in_byte = 8'h00;
      req_chan_if.in_last = 1'b0;
      csr_write_en        = 1'b0;
      csr_index           = sfr_pkg::CSR_PATTERN_BYTES;
      csr_wdata           = '0;
      reset               = 1'b1;
      cfg_pattern         = '0;
      cfg_pattern_len     = '0;
      cfg_value           = '0;
      cfg_value_len       = '0;
      win_fill            = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;

      test_pass_through();
      test_replace();
      test_empty_end();
      test_oversized_lengths();
      test_window_drop();
      test_random_streams();

      // drain and look for leftovers
      req_chan_if.valid <= 1'b0;
      for (int k = 0; k < 4000 && out_stream_q.size() != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (out_stream_q.size() != 0) begin
         $display("tb: %0d expected words never arrived", out_stream_q.size());
         fail_count += out_stream_q.size();
      end

      $display("tb: %0d source words over %0d register setups, %0d result words checked",
               words_sent, setups_done, words_seen);
      $display("tb: covered pass-through, replace, delete, clamped lengths, window drop");
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d failures", fail_count);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
